@@ rtl/slx_pkg.sv @@
// Shared types, token codes and keyword tables for the SQL subset lexer.
`default_nettype none

package slx_pkg;

    localparam int POS_WIDTH_DEF = 16;
    localparam int NUM_KW        = 14;
    localparam int KW_MAX_LEN    = 8;
    localparam int MAX_TOKENS    = 3;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_FRAC,
        MODE_STR,
        MODE_DONE
    } mode_t;

    localparam logic [4:0] KIND_IDENT   = 5'd14;
    localparam logic [4:0] KIND_INT     = 5'd15;
    localparam logic [4:0] KIND_FLOAT   = 5'd16;
    localparam logic [4:0] KIND_STRING  = 5'd17;
    localparam logic [4:0] KIND_LPAREN  = 5'd18;
    localparam logic [4:0] KIND_RPAREN  = 5'd19;
    localparam logic [4:0] KIND_COMMA   = 5'd20;
    localparam logic [4:0] KIND_STAR    = 5'd21;
    localparam logic [4:0] KIND_EQUAL   = 5'd22;
    localparam logic [4:0] KIND_LESS    = 5'd23;
    localparam logic [4:0] KIND_GREATER = 5'd24;
    localparam logic [4:0] KIND_SEMI    = 5'd25;
    localparam logic [4:0] KIND_UNKNOWN = 5'd26;
    localparam logic [4:0] KIND_END     = 5'd27;

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam logic [7:0] KW_CHAR [NUM_KW][KW_MAX_LEN] = '{
        '{"S", "E", "L", "E", "C", "T", 8'h00, 8'h00},
        '{"I", "N", "S", "E", "R", "T", 8'h00, 8'h00},
        '{"U", "P", "D", "A", "T", "E", 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
        '{"C", "R", "E", "A", "T", "E", 8'h00, 8'h00},
        '{"D", "R", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"T", "A", "B", "L", "E", 8'h00, 8'h00, 8'h00},
        '{"I", "N", "T", "O", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"V", "A", "L", "U", "E", "S", 8'h00, 8'h00},
        '{"F", "R", "O", "M", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"W", "H", "E", "R", "E", 8'h00, 8'h00, 8'h00},
        '{"I", "N", "T", "E", "G", "E", "R", 8'h00},
        '{"T", "E", "X", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"F", "L", "O", "A", "T", 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd4, 3'd5,
        3'd4, 3'd6, 3'd4, 3'd5, 3'd7, 3'd4, 3'd5
    };

    typedef struct packed {
        logic [15:0] length;
        logic [15:0] start;
        logic [4:0]  kind;
    } tok_t;

    typedef struct packed {
        tok_t [MAX_TOKENS-1:0] tok;
        logic [1:0]            count;
    } batch_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic logic [NUM_KW-1:0] kw_match(input logic       k_ok,
                                                   input logic [2:0] k,
                                                   input logic [7:0] c);
        logic [NUM_KW-1:0] m;
        logic [7:0]        u;
        m = '0;
        u = to_upper(c);
        for (int i = 0; i < NUM_KW; i++)
        begin
            m[i] = k_ok && (k < KW_LEN[i]) && (KW_CHAR[i][k] == u);
        end
        return m;
    endfunction

    function automatic logic [4:0] sym_kind(input logic [7:0] c);
        logic [4:0] kind;
        unique case (c)
            "(":     kind = KIND_LPAREN;
            ")":     kind = KIND_RPAREN;
            ",":     kind = KIND_COMMA;
            "*":     kind = KIND_STAR;
            "=":     kind = KIND_EQUAL;
            "<":     kind = KIND_LESS;
            ">":     kind = KIND_GREATER;
            ";":     kind = KIND_SEMI;
            default: kind = KIND_UNKNOWN;
        endcase
        return kind;
    endfunction

endpackage

`default_nettype wire

@@ rtl/slx_core.sv @@
// Lexer state and the token batch that one input byte produces.
`default_nettype none

module slx_core
    import slx_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output batch_t          batch
);

    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    typedef struct packed {
        logic valid;
        tok_t tok;
    } slot_t;

    mode_t                 mode_reg, mode_next, mode_a;
    logic [POS_WIDTH-1:0]  pos_reg, pos_next, pos_inc;
    logic [POS_WIDTH-1:0]  begin_reg, begin_next, begin_a, offset;
    logic [NUM_KW-1:0]     cand_reg, cand_next, cand_a;
    slot_t                 tok_a, tok_s, tok_f, tok_e;
    slot_t                 src [4];
    logic                  extend;
    logic [1:0]            n;

    function automatic slot_t finish(input mode_t                m,
                                     input logic [POS_WIDTH-1:0] b,
                                     input logic [NUM_KW-1:0]    cand,
                                     input logic [POS_WIDTH-1:0] e);
        slot_t                r;
        logic [POS_WIDTH-1:0] len;
        logic [4:0]           kind;
        len  = e - b;
        kind = KIND_IDENT;
        for (int i = NUM_KW - 1; i >= 0; i--)
        begin
            if (cand[i] && len == POS_WIDTH'(KW_LEN[i]))
                kind = 5'(i);
        end
        r.valid      = 1'b1;
        r.tok.start  = 16'(b);
        r.tok.length = 16'(len);
        unique case (m)
            MODE_IDENT: r.tok.kind = kind;
            MODE_INT:   r.tok.kind = KIND_INT;
            MODE_FRAC:  r.tok.kind = KIND_FLOAT;
            MODE_STR:
            begin
                r.tok.kind   = KIND_STRING;
                r.tok.length = (len == '0) ? 16'd0 : 16'(len - 1'b1);
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            begin_reg <= '0;
            cand_reg  <= '0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            cand_reg  <= cand_next;
        end
    end

    always_comb
    begin
        pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        offset  = pos_reg - begin_reg;
        mode_a  = mode_reg;
        begin_a = begin_reg;
        cand_a  = cand_reg;
        extend  = 1'b0;
        tok_a   = '0;
        tok_s   = '0;
        tok_f   = '0;
        tok_e   = '0;

        mode_next  = mode_reg;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        cand_next  = cand_reg;

        if (mode_reg == MODE_DONE)
        begin
            mode_next = MODE_DONE;
        end
        else if (in_byte == 8'd0)
        begin
            tok_a            = finish(mode_reg, begin_reg, cand_reg, pos_reg);
            tok_e.valid      = 1'b1;
            tok_e.tok.kind   = KIND_END;
            tok_e.tok.start  = 16'(pos_reg);
            tok_e.tok.length = 16'd0;
            mode_next        = MODE_DONE;
            cand_next        = '0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_alpha(in_byte) || is_digit(in_byte) || in_byte == CH_UNDER)
                    begin
                        extend = 1'b1;
                        if (pos_reg == POS_MAX)
                            cand_a = '0;
                        else
                            cand_a = cand_reg & kw_match((offset >> 3) == '0,
                                                         offset[2:0], in_byte);
                    end
                end
                MODE_INT:
                begin
                    if (is_digit(in_byte))
                        extend = 1'b1;
                    else if (in_byte == CH_DOT)
                    begin
                        extend = 1'b1;
                        mode_a = MODE_FRAC;
                    end
                end
                MODE_FRAC:
                begin
                    extend = is_digit(in_byte);
                end
                MODE_STR:
                begin
                    extend = 1'b1;
                    if (in_byte == CH_QUOTE)
                    begin
                        tok_a  = finish(MODE_STR, begin_reg, cand_reg, pos_reg);
                        mode_a = MODE_IDLE;
                    end
                end
                default:
                begin
                    extend = 1'b0;
                end
            endcase

            if (!extend)
            begin
                tok_a   = finish(mode_reg, begin_reg, cand_reg, pos_reg);
                begin_a = pos_reg;
                cand_a  = '0;
                mode_a  = MODE_IDLE;
                if (is_alpha(in_byte) || in_byte == CH_UNDER)
                begin
                    mode_a = MODE_IDENT;
                    cand_a = kw_match(1'b1, 3'd0, in_byte);
                end
                else if (is_digit(in_byte))
                    mode_a = MODE_INT;
                else if (in_byte == CH_QUOTE)
                    mode_a = MODE_STR;
                else if (!is_space(in_byte))
                begin
                    tok_s.valid      = 1'b1;
                    tok_s.tok.kind   = sym_kind(in_byte);
                    tok_s.tok.start  = 16'(pos_reg);
                    tok_s.tok.length = 16'd1;
                end
            end

            pos_next   = pos_inc;
            begin_next = begin_a;
            if (in_last)
            begin
                tok_f            = finish(mode_a, begin_a, cand_a, pos_inc);
                tok_e.valid      = 1'b1;
                tok_e.tok.kind   = KIND_END;
                tok_e.tok.start  = 16'(pos_inc);
                tok_e.tok.length = 16'd0;
                mode_next        = MODE_DONE;
                cand_next        = '0;
            end
            else
            begin
                mode_next = mode_a;
                cand_next = cand_a;
            end
        end
    end

    always_comb
    begin
        src[0] = tok_a;
        src[1] = tok_s;
        src[2] = tok_f;
        src[3] = tok_e;
        batch  = '0;
        n      = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (src[i].valid && n != 2'd3)
            begin
                batch.tok[n] = src[i].tok;
                n            = n + 2'd1;
            end
        end
        batch.count = n;
    end

endmodule

`default_nettype wire

@@ rtl/slx_out_queue.sv @@
// Result batch register that hands tokens out one beat at a time.
`default_nettype none

module slx_out_queue
    import slx_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   take,
    input  wire batch_t batch,
    output logic        free,
    output logic        out_valid,
    input  wire logic   out_ready,
    output tok_t        out_tok,
    output logic        out_last
);

    tok_t [MAX_TOKENS-1:0] tok_reg;
    logic [1:0]            cnt_reg, cnt_next;
    logic [1:0]            idx_reg, idx_next;
    logic                  at_last;

    assign out_valid = idx_reg < cnt_reg;
    assign at_last   = idx_reg == cnt_reg - 2'd1;
    assign out_last  = at_last;
    assign free      = !out_valid || (out_ready && at_last);

    always_comb
    begin
        unique case (idx_reg)
            2'd1:    out_tok = tok_reg[1];
            2'd2:    out_tok = tok_reg[2];
            default: out_tok = tok_reg[0];
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (take)
        begin
            cnt_next = batch.count;
            idx_next = 2'd0;
        end
        else if (out_valid && out_ready)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            tok_reg <= batch.tok;
    end

endmodule

`default_nettype wire

@@ rtl/sql_subset_lexer.sv @@
// Top level of the streaming SQL subset lexer.
//
//  channel  | dir | payload
//  s_axis   | in  | tdata[7:0] byte, tlast final byte
//  m_axis   | out | tdata[4:0] kind, [20:5] start, [36:21] length; tlast last token of byte
//
// One byte is taken per cycle while the output register is free; its first token is
// valid the cycle after the byte is taken, and its up to three tokens leave one per
// cycle while m_axis_tready is high. The one-batch output register sets the rate: a
// byte waits for the batch before it to leave, so bytes with at most one token
// stream at one per cycle while the output is ready. Reset returns the lexer to idle
// at position zero; after the end token all bytes are taken and dropped until reset.
// A stalled output beat holds the input until the last token of the batch leaves.
`default_nettype none

module sql_subset_lexer
    import slx_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [4:0] token_kind, [20:5] token_start,
                                             // [36:21] token_length, [39:37] zero
    output logic             m_axis_tlast
);

    batch_t batch;
    tok_t   out_tok;
    logic   take;
    logic   free;

    assign s_axis_tready = free;
    assign take          = s_axis_tvalid && free;
    assign m_axis_tdata  = {3'b000, out_tok};

    slx_core #(
        .POS_WIDTH(POS_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (s_axis_tdata),
        .in_last (s_axis_tlast),
        .batch   (batch)
    );

    slx_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .batch     (batch),
        .free      (free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tok   (out_tok),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/slx_checker.sv @@
// Port-level checks for the SQL subset lexer and their binding.
`default_nettype none

module slx_checker
    import slx_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    logic seen_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_end_reg <= 1'b0;
        else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[4:0] == KIND_END)
            seen_end_reg <= 1'b1;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_nothing_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        seen_end_reg |-> !m_axis_tvalid)
        else $error("token after end token");

    a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4:0] == KIND_END
        |-> m_axis_tlast && m_axis_tdata[36:21] == 16'd0)
        else $error("end token not last or nonzero length");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:0] <= KIND_END && m_axis_tdata[39:37] == 3'b000)
        else $error("bad token kind or pad bits");

    a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken while batch pending");

endmodule

bind sql_subset_lexer slx_checker u_slx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
